/* rtl/text_line_frame_parser_assert.svh */
// Assertion macros shared by the text line frame parser modules.
`ifndef TEXT_LINE_FRAME_PARSER_ASSERT_SVH
`define TEXT_LINE_FRAME_PARSER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TLFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TLFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tlfp_pkg.sv */
// Shared constants and types for the text line frame parser.
package tlfp_pkg;

    // Frame and line limits
    localparam int FRAME_MAX    = 512;
    localparam int LINE_MAX     = 64;
    localparam int RECENT_DEPTH = 10;
    localparam int END_LEN      = 9;
    localparam int Q_DEPTH      = 4;

    // Derived widths
    localparam int CNT_W   = $clog2(FRAME_MAX + 1);
    localparam int LEN_SAT = LINE_MAX + 3;
    localparam int LEN_W   = $clog2(LEN_SAT + 1);
    localparam int IDX_W   = $clog2(LINE_MAX);
    localparam int N_W     = $clog2(LINE_MAX + 1);
    localparam int ADDR_W  = IDX_W + 1;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // Frame end text "Checksum<TAB>", oldest byte first
    localparam logic [7:0] END_TEXT [0:END_LEN-1] = '{
        8'h43, 8'h68, 8'h65, 8'h63, 8'h6B, 8'h73, 8'h75, 8'h6D, 8'h09
    };

    // Result kinds
    typedef enum logic [2:0] {
        K_BYTE  = 3'd0,
        K_EMPTY = 3'd1,
        K_OK    = 3'd2,
        K_BAD   = 3'd3,
        K_OVER  = 3'd4
    } t_kind;

    // Command from the classifier to the emitter
    typedef struct packed {
        t_kind          kind;
        logic [N_W-1:0] len;
        logic           trunc;
        logic           bank;
    } t_cmd;

    // Line store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    // Bank release from the emitter
    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

endpackage

/* rtl/tlfp_queue.sv */
// Short command queue between the classifier and the emitter.
module tlfp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tlfp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output tlfp_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);

    tlfp_pkg::t_cmd                 r_slot [tlfp_pkg::Q_DEPTH];
    logic [tlfp_pkg::QP_W-1:0]      r_wp;
    logic [tlfp_pkg::QP_W-1:0]      r_rp;
    logic [tlfp_pkg::QC_W-1:0]      r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == tlfp_pkg::QC_W'(tlfp_pkg::Q_DEPTH));
    assign o_head  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/tlfp_front.sv */
// Byte classifier: frame phase, checksum, line capture and command issue.
`include "text_line_frame_parser_assert.svh"

module tlfp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_rx_byte,
    output logic           o_stall,
    input  logic           i_q_full,
    output logic           o_push,
    output tlfp_pkg::t_cmd o_cmd,
    output tlfp_pkg::t_wr  o_wr,
    input  tlfp_pkg::t_rel i_rel
);

    typedef enum logic {
        PH_IDLE,
        PH_FRAME
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [tlfp_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [7:0]                      r_sum, n_sum;
    logic [tlfp_pkg::LEN_W-1:0]      r_len, n_len;
    logic [7:0]                      r_recent [tlfp_pkg::RECENT_DEPTH];
    logic [7:0]                      n_recent [tlfp_pkg::RECENT_DEPTH];
    logic                            r_bank, n_bank;
    logic [1:0]                      r_busy, n_busy;

    logic                            acc;
    logic [tlfp_pkg::CNT_W-1:0]      cnt_inc;
    logic [7:0]                      sum_inc;
    logic [tlfp_pkg::LEN_W-1:0]      len_inc;
    logic [tlfp_pkg::LEN_W-1:0]      content;
    logic                            trunc;
    logic [tlfp_pkg::N_W-1:0]        line_n;
    logic                            crlf;
    logic                            end_hit;
    logic                            set_busy;

    assign acc     = i_valid && !o_stall;
    assign o_stall = i_q_full || r_busy[r_bank];
    assign cnt_inc = r_cnt + 1'b1;
    assign sum_inc = r_sum + i_rx_byte;
    assign len_inc = (r_len == tlfp_pkg::LEN_W'(tlfp_pkg::LEN_SAT)) ? r_len : r_len + 1'b1;
    assign content = (len_inc >= tlfp_pkg::LEN_W'(2)) ? len_inc - tlfp_pkg::LEN_W'(2) : '0;
    assign trunc   = (content > tlfp_pkg::LEN_W'(tlfp_pkg::LINE_MAX));
    assign line_n  = trunc ? tlfp_pkg::N_W'(tlfp_pkg::LINE_MAX) : tlfp_pkg::N_W'(content);
    assign crlf    = (i_rx_byte == tlfp_pkg::CHAR_LF) && (r_recent[0] == tlfp_pkg::CHAR_CR);

    // Match the nine bytes before this one against the end text
    always_comb begin
        end_hit = 1'b1;
        for (int x = 0; x < tlfp_pkg::END_LEN; x++) begin
            if (r_recent[tlfp_pkg::END_LEN - 1 - x] != tlfp_pkg::END_TEXT[x]) begin
                end_hit = 1'b0;
            end
        end
    end

    // Write frame bytes into the current bank while the line fits
    always_comb begin
        o_wr.en   = acc && (r_phase == PH_FRAME)
                    && (r_len < tlfp_pkg::LEN_W'(tlfp_pkg::LINE_MAX));
        o_wr.addr = {r_bank, r_len[tlfp_pkg::IDX_W-1:0]};
        o_wr.data = i_rx_byte;
    end

    // Classify the accepted byte
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_len     = r_len;
        n_recent  = r_recent;
        n_bank    = r_bank;
        set_busy  = 1'b0;
        o_push    = 1'b0;
        o_cmd.kind  = tlfp_pkg::K_OVER;
        o_cmd.len   = '0;
        o_cmd.trunc = 1'b0;
        o_cmd.bank  = r_bank;
        if (acc) begin
            n_recent[0] = i_rx_byte;
            for (int i = 1; i < tlfp_pkg::RECENT_DEPTH; i++) begin
                n_recent[i] = r_recent[i-1];
            end
            n_sum = sum_inc;
            n_cnt = cnt_inc;
            if (r_phase == PH_FRAME) begin
                n_len = len_inc;
            end
            if (cnt_inc >= tlfp_pkg::CNT_W'(tlfp_pkg::FRAME_MAX)) begin
                // Frame limit: drop everything and report
                o_push     = 1'b1;
                o_cmd.kind = tlfp_pkg::K_OVER;
                n_phase    = PH_IDLE;
                n_cnt      = '0;
                n_sum      = '0;
                n_len      = '0;
                for (int i = 0; i < tlfp_pkg::RECENT_DEPTH; i++) begin
                    n_recent[i] = '0;
                end
            end else if (r_phase == PH_IDLE) begin
                if (crlf) begin
                    n_phase = PH_FRAME;
                    n_len   = '0;
                end
            end else if (crlf) begin
                // Line close: hand the bank over when it holds bytes
                o_push = 1'b1;
                n_len  = '0;
                if (line_n == '0) begin
                    o_cmd.kind = tlfp_pkg::K_EMPTY;
                end else begin
                    o_cmd.kind  = tlfp_pkg::K_BYTE;
                    o_cmd.len   = line_n;
                    o_cmd.trunc = trunc;
                    set_busy    = 1'b1;
                    n_bank      = ~r_bank;
                end
            end else if (end_hit) begin
                // Frame end: judge the sum and reset
                o_push     = 1'b1;
                o_cmd.kind = (sum_inc == 8'd0) ? tlfp_pkg::K_OK : tlfp_pkg::K_BAD;
                n_phase    = PH_IDLE;
                n_cnt      = '0;
                n_sum      = '0;
                n_len      = '0;
                for (int i = 0; i < tlfp_pkg::RECENT_DEPTH; i++) begin
                    n_recent[i] = '0;
                end
            end
        end
    end

    // Track which banks are still being emitted
    always_comb begin
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (set_busy) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    // Hold classifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_len   <= '0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
            for (int i = 0; i < tlfp_pkg::RECENT_DEPTH; i++) begin
                r_recent[i] <= '0;
            end
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_len    <= n_len;
            r_bank   <= n_bank;
            r_busy   <= n_busy;
            r_recent <= n_recent;
        end
    end

    `TLFP_ASSERT_SAME(a_wr_free_bank, o_wr.en, !r_busy[o_wr.addr[tlfp_pkg::IDX_W]], "line write into a bank still being emitted")
    `TLFP_ASSERT_SAME(a_push_room, o_push, !i_q_full, "command pushed into a full queue")
    `TLFP_ASSERT_SAME(a_idle_over_only, o_push && (r_phase == PH_IDLE), o_cmd.kind == tlfp_pkg::K_OVER, "idle byte issued a frame command")

endmodule

/* rtl/tlfp_back.sv */
// Result emitter: line store and output register.
`include "text_line_frame_parser_assert.svh"

module tlfp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlfp_pkg::t_wr  i_wr,
    input  logic           i_q_empty,
    input  tlfp_pkg::t_cmd i_head,
    output logic           o_pop,
    output tlfp_pkg::t_rel o_rel,
    output logic           o_valid,
    output logic [2:0]     o_kind,
    output logic [7:0]     o_data,
    output logic           o_last,
    output logic           o_truncated,
    input  logic           i_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EMIT
    } t_state;

    logic [7:0]                  r_mem [2**tlfp_pkg::ADDR_W];
    logic [7:0]                  r_rd_data;

    t_state                      r_state, n_state;
    logic [tlfp_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                        r_ov, n_ov;
    tlfp_pkg::t_kind             r_kind, n_kind;
    logic [7:0]                  r_data, n_data;
    logic                        r_last, n_last;
    logic                        r_trunc, n_trunc;

    logic                        out_free;
    logic                        is_last;

    assign out_free    = !r_ov || !i_stall;
    assign is_last     = (tlfp_pkg::N_W'(r_idx) + tlfp_pkg::N_W'(1)) == i_head.len;
    assign o_valid     = r_ov;
    assign o_kind      = r_kind;
    assign o_data      = r_data;
    assign o_last      = r_last;
    assign o_truncated = r_trunc;

    // Line store: write from the classifier, registered read for emission
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (r_state == S_FETCH) begin
            r_rd_data <= r_mem[{i_head.bank, r_idx}];
        end
    end

    // Walk commands and fill the output register
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_ov    = r_ov;
        n_kind  = r_kind;
        n_data  = r_data;
        n_last  = r_last;
        n_trunc = r_trunc;
        o_pop   = 1'b0;
        o_rel.valid = 1'b0;
        o_rel.bank  = i_head.bank;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_head.kind == tlfp_pkg::K_BYTE) begin
                        n_idx   = '0;
                        n_state = S_FETCH;
                    end else if (out_free) begin
                        n_ov    = 1'b1;
                        n_kind  = i_head.kind;
                        n_data  = '0;
                        n_last  = 1'b1;
                        n_trunc = i_head.trunc;
                        o_pop   = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = tlfp_pkg::K_BYTE;
                    n_data  = r_rd_data;
                    n_last  = is_last;
                    n_trunc = i_head.trunc;
                    if (is_last) begin
                        o_pop       = 1'b1;
                        o_rel.valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
        r_kind  <= n_kind;
        r_data  <= n_data;
        r_last  <= n_last;
        r_trunc <= n_trunc;
    end

    `TLFP_ASSERT_SAME(a_rel_in_emit, o_rel.valid, r_state == S_EMIT, "bank released outside emission")
    `TLFP_ASSERT_SAME(a_line_nonzero, !i_q_empty && (i_head.kind == tlfp_pkg::K_BYTE), i_head.len != '0, "line command with no bytes")
    `TLFP_ASSERT_SAME(a_idx_in_line, r_state != S_IDLE, tlfp_pkg::N_W'(r_idx) < i_head.len, "line index past line length")
    `TLFP_ASSERT_NEXT(a_fetch_to_emit, r_state == S_FETCH, r_state == S_EMIT, "read not followed by emission")

endmodule

/* rtl/text_line_frame_parser.sv */
// Top level of the CR LF text frame parser with modulo-256 checksum.
//
// Takes one received byte per item and reports text lines and frame verdicts.
// An input item is taken whenever o_stall is low. o_stall rises while the
// four-entry command queue is full, or while the line bank that the next
// bytes would fill is still being sent out (the line store has two banks of
// 64 bytes, so one line can be emitted while the next is captured).
// Each line byte result passes through a line store read, then the output
// register; empty line, frame ok, bad sum and overflow results go straight
// to the output register. No clearing pass follows reset: only bytes of
// the current line are ever read back.
module text_line_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    output logic [2:0] o_kind,
    output logic [7:0] o_data,
    output logic       o_last,
    output logic       o_truncated,
    input  logic       i_stall
);

    tlfp_pkg::t_cmd push_cmd;
    tlfp_pkg::t_cmd head_cmd;
    tlfp_pkg::t_wr  line_wr;
    tlfp_pkg::t_rel bank_rel;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;

    // Classify incoming bytes
    tlfp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .o_wr      (line_wr),
        .i_rel     (bank_rel)
    );

    // Buffer commands
    tlfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Emit results
    tlfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (line_wr),
        .i_q_empty   (q_empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .o_rel       (bank_rel),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_last      (o_last),
        .o_truncated (o_truncated),
        .i_stall     (i_stall)
    );

endmodule

/* verif/tb_text_line_frame_parser.sv */
// Self-checking testbench for the CR LF text frame parser with modulo-256 checksum.
module tb_text_line_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEN_CAP      = 1023;
    localparam int unsigned RANDOM_BYTES = 60;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 2 * tlfp_pkg::LINE_MAX + 32;
    // frame end text, oldest byte in the top bits
    localparam logic [71:0] END_BITS     = "Checksum\t";

    typedef struct packed {
        tlfp_pkg::t_kind kind;
        logic [7:0]      data;
        logic            last;
        logic            truncated;
    } t_line_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic [7:0] i_rx_byte;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_kind;
    logic [7:0] o_data;
    logic       o_last;
    logic       o_truncated;
    logic       i_stall;

    // parser state as the testbench sees it
    logic        frame_open;
    int unsigned rx_count;
    logic [7:0]  frame_sum;
    logic [7:0]  recent [tlfp_pkg::RECENT_DEPTH];
    logic [7:0]  line_buf [tlfp_pkg::LINE_MAX];
    int unsigned line_len;

    t_line_result due_results [$];
    int unsigned  sent_bytes;
    int unsigned  failures;
    int unsigned  quiet_cycles;
    bit           rx_gaps_on    = 1'b1;
    bit           out_stalls_on = 1'b1;

    text_line_frame_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_rx_byte   (i_rx_byte),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_last      (o_last),
        .o_truncated (o_truncated),
        .i_stall     (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_frame_state();
        frame_open = 1'b0;
        rx_count   = 0;
        frame_sum  = 8'h00;
        line_len   = 0;
        foreach (recent[i]) recent[i] = 8'h00;
    endfunction

    function automatic void queue_result(tlfp_pkg::t_kind k, logic [7:0] d, logic l, logic t);
        t_line_result r;
        r.kind      = k;
        r.data      = d;
        r.last      = l;
        r.truncated = t;
        due_results.push_back(r);
    endfunction

    // Advance the parser state by one byte and queue the results it causes
    function automatic void advance_frame_state(logic [7:0] c);
        int unsigned     n;
        int              i;
        logic            clipped;
        logic            crlf;
        logic [71:0]     window;
        tlfp_pkg::t_kind verdict;
        for (i = tlfp_pkg::RECENT_DEPTH - 1; i > 0; i--) recent[i] = recent[i - 1];
        recent[0] = c;
        frame_sum = frame_sum + c;
        rx_count++;
        if (frame_open) begin
            if (line_len < tlfp_pkg::LINE_MAX) line_buf[line_len] = c;
            if (line_len < LEN_CAP) line_len++;
        end

        // frame byte limit: drop the byte and start over
        if (rx_count >= tlfp_pkg::FRAME_MAX) begin
            clear_frame_state();
            queue_result(tlfp_pkg::K_OVER, 8'h00, 1'b1, 1'b0);
            return;
        end

        crlf = rx_count >= 2 && recent[0] == tlfp_pkg::CHAR_LF
               && recent[1] == tlfp_pkg::CHAR_CR;
        window = {recent[9], recent[8], recent[7], recent[6], recent[5],
                  recent[4], recent[3], recent[2], recent[1]};
        if (!frame_open) begin
            // bytes before the first CR LF only open the frame
            if (crlf) begin
                frame_open = 1'b1;
                line_len   = 0;
            end
        end else if (crlf) begin
            // emit the line without its CR LF, cut at the store size
            n        = line_len >= 2 ? line_len - 2 : 0;
            line_len = 0;
            clipped  = n > tlfp_pkg::LINE_MAX;
            if (clipped) n = tlfp_pkg::LINE_MAX;
            if (n == 0) queue_result(tlfp_pkg::K_EMPTY, 8'h00, 1'b1, clipped);
            for (i = 0; i < n; i++) begin
                queue_result(tlfp_pkg::K_BYTE, line_buf[i], i + 1 == n, clipped);
            end
        end else if (rx_count >= tlfp_pkg::RECENT_DEPTH && window == END_BITS) begin
            // end text plus one byte: judge the sum, then start over
            if (frame_sum == 8'h00) verdict = tlfp_pkg::K_OK;
            else verdict = tlfp_pkg::K_BAD;
            queue_result(verdict, 8'h00, 1'b1, 1'b0);
            clear_frame_state();
        end
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= 10) $display("error at %0t: %s", $realtime, msg);
    endfunction

    // Send one item, with an optional gap ahead of it
    task automatic send_rx_byte(input logic [7:0] b);
        if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        advance_frame_state(b);
        sent_bytes++;
    endtask

    task automatic send_crlf();
        send_rx_byte(tlfp_pkg::CHAR_CR);
        send_rx_byte(tlfp_pkg::CHAR_LF);
    endtask

    // Send the first count bytes of the frame end text
    task automatic send_end_text(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) send_rx_byte(END_BITS[(8 - k) * 8 +: 8]);
    endtask

    // Close the frame with a final byte that zeroes the sum, or misses it
    task automatic send_checksum_trailer(input bit good);
        logic [7:0] fix;
        send_end_text(9);
        fix = 8'h00 - frame_sum;
        if (!good) fix = fix + 8'($urandom_range(1, 255));
        send_rx_byte(fix);
    endtask

    // Hold the output in random bursts of stalls
    initial begin : stall_driver
        int unsigned span;
        forever begin
            if (out_stalls_on && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                span = $urandom_range(1, 16);
            end else begin
                i_stall <= 1'b0;
                span = $urandom_range(1, 24);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    // Compare each accepted result with the oldest one due
    always @(posedge i_clk) begin : check_results
        t_line_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (due_results.size() == 0) begin
                note_failure($sformatf(
                    "result with none due: kind %0d data %02h last %0b trunc %0b",
                    o_kind, o_data, o_last, o_truncated));
            end else begin
                want = due_results.pop_front();
                if (o_kind !== want.kind || o_data !== want.data ||
                    o_last !== want.last || o_truncated !== want.truncated) begin
                    note_failure($sformatf(
                        {"expected kind %0d data %02h last %0b trunc %0b, ",
                         "got kind %0d data %02h last %0b trunc %0b"},
                        want.kind, want.data, want.last, want.truncated,
                        o_kind, o_data, o_last, o_truncated));
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no progress for %0d cycles, %0d results still due",
                     quiet_cycles, due_results.size());
            $display("text_line_frame_parser: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Idle noise, stray CR and LF and the end text give nothing before a frame opens
    task automatic test_idle_bytes();
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        send_rx_byte(tlfp_pkg::CHAR_CR);
        send_rx_byte(8'h78);
        send_rx_byte(tlfp_pkg::CHAR_LF);
        send_end_text(9);
        send_rx_byte(8'h55);
    endtask

    // Line bytes, an empty line and a good frame, idle bytes counted in the sum
    task automatic test_line_kinds();
        send_crlf();
        send_rx_byte(8'h41);
        send_rx_byte(8'hFF);
        send_rx_byte(8'h00);
        send_crlf();
        send_crlf();
        send_checksum_trailer(1'b1);
    endtask

    task automatic test_bad_sum();
        send_crlf();
        send_rx_byte(8'h7A);
        send_crlf();
        send_checksum_trailer(1'b0);
    endtask

    // A line that just fits the store and one that is cut
    task automatic test_long_lines();
        send_crlf();
        repeat (tlfp_pkg::LINE_MAX) send_rx_byte(8'($urandom));
        send_crlf();
        repeat (tlfp_pkg::LINE_MAX + 1) send_rx_byte(8'($urandom));
        send_crlf();
        send_checksum_trailer(1'b1);
    endtask

    // Mostly well-formed frames with random content, some broken or left open
    task automatic test_random_frames();
        int unsigned goal;
        int unsigned calm_from;
        int unsigned len;
        int unsigned pick;
        goal      = sent_bytes + RANDOM_BYTES;
        calm_from = sent_bytes + RANDOM_BYTES * 3 / 4;
        while (sent_bytes < goal) begin
            if (sent_bytes >= calm_from) begin
                rx_gaps_on    = 1'b0;
                out_stalls_on = 1'b0;
            end
            repeat ($urandom_range(0, 3)) send_rx_byte(8'($urandom));
            send_crlf();
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(0, 9) == 0) len = $urandom_range(60, 100);
                else len = $urandom_range(0, 8);
                repeat (len) send_rx_byte(8'($urandom));
                send_crlf();
            end
            pick = $urandom_range(0, 7);
            if (pick <= 3) begin
                send_checksum_trailer(1'b1);
            end else if (pick <= 5) begin
                send_checksum_trailer(1'b0);
            end else if (pick == 6) begin
                // break off the end text and close the line instead
                send_end_text($urandom_range(1, 8));
                send_crlf();
            end
            // otherwise leave the frame open and run on into the next one
        end
        rx_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= 8'h00;
        sent_bytes = 0;
        failures   = 0;
        clear_frame_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_bytes();
        test_line_kinds();
        test_bad_sum();
        test_long_lines();
        test_random_frames();
        i_valid <= 1'b0;

        // drain what is still due, then watch for stray results
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("text_line_frame_parser: match");
        end else begin
            $display("text_line_frame_parser: mismatch");
        end
        $finish;
    end

endmodule
